// ----- rtl/hmq_pkg.sv -----
// Shared types and codes for the binary min-heap queue unit.
`default_nettype none

package hmq_pkg;

  // Operation codes on the input channel
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Width of the reported entry count
  localparam int COUNT_W = 11;

  // One heap entry: key in the upper half, payload in the lower half
  typedef struct packed {
    logic signed [31:0] key;
    logic [31:0]        payload;
  } entry_t;

  // Request handed from the port to the sequencer
  typedef struct packed {
    logic   op;
    entry_t ent;
  } req_t;

  // Result handed from the sequencer to the output register
  typedef struct packed {
    entry_t               popped;
    entry_t               top;
    logic [COUNT_W-1:0]   count;
    logic [1:0]           status;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/hmq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hmq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/hmq_ctrl.sv -----
// Heap sequencer: sift-up and sift-down over one shared key comparator.
`default_nettype none

module hmq_ctrl #(
  parameter int CAPACITY = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire hmq_pkg::req_t     req,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output hmq_pkg::res_t          res,
  // memory port
  output logic                          mem_we,
  output logic [$clog2(CAPACITY)-1:0]   mem_waddr,
  output hmq_pkg::entry_t               mem_wdata,
  output logic [$clog2(CAPACITY)-1:0]   mem_raddr,
  input  wire hmq_pkg::entry_t          mem_rdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;
  localparam int EW = (CW > hmq_pkg::COUNT_W) ? CW : hmq_pkg::COUNT_W;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_UP_RD   = 10'b00_0000_0010,
    S_UP_CMP  = 10'b00_0000_0100,
    S_FIN     = 10'b00_0000_1000,
    S_DN_LAST = 10'b00_0001_0000,
    S_DN_RDL  = 10'b00_0010_0000,
    S_DN_RDR  = 10'b00_0100_0000,
    S_DN_CMP  = 10'b00_1000_0000,
    S_DN_SEL  = 10'b01_0000_0000,
    S_DONE    = 10'b10_0000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [AW-1:0]     cidx_r, cidx_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  hmq_pkg::entry_t   cur_r, cur_nxt;
  hmq_pkg::entry_t   child_r, child_nxt;
  hmq_pkg::entry_t   popped_r, popped_nxt;
  hmq_pkg::entry_t   top_r;
  logic [1:0]        status_r, status_nxt;

  logic [IW-1:0]     left_w, right_w, cnt_w;
  logic [AW-1:0]     parent_w;
  logic [CW-1:0]     cnt_dec_w;
  logic [EW-1:0]     cnt_ext_w;

  // Shared comparator: a <= b on signed keys
  logic signed [31:0] cmp_a, cmp_b;
  logic               cmp_le;

  // Tree index arithmetic
  assign left_w    = {1'b0, pos_r, 1'b1};
  assign right_w   = left_w + IW'(1);
  assign cnt_w     = IW'(cnt_r);
  assign parent_w  = (pos_r - AW'(1)) >> 1;
  assign cnt_dec_w = cnt_r - CW'(1);
  assign cnt_ext_w = EW'(cnt_r);

  // Operand select for the comparator
  always_comb begin
    cmp_a = cur_r.key;
    cmp_b = child_r.key;
    case (state_r)
      S_UP_CMP: begin
        cmp_a = mem_rdata.key;
        cmp_b = cur_r.key;
      end
      S_DN_CMP: begin
        cmp_a = child_r.key;
        cmp_b = mem_rdata.key;
      end
      default: begin
        cmp_a = cur_r.key;
        cmp_b = child_r.key;
      end
    endcase
  end

  assign cmp_le = (cmp_a <= cmp_b);

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    cidx_nxt   = cidx_r;
    cnt_nxt    = cnt_r;
    cur_nxt    = cur_r;
    child_nxt  = child_r;
    popped_nxt = popped_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    mem_waddr  = pos_r;
    mem_wdata  = cur_r;
    mem_raddr  = parent_w;

    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          popped_nxt = '0;
          status_nxt = hmq_pkg::ST_DONE;
          if (req.op == hmq_pkg::OP_PUSH) begin
            if (cnt_r == CW'(CAPACITY)) begin
              status_nxt = hmq_pkg::ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              pos_nxt   = cnt_r[AW-1:0];
              cnt_nxt   = cnt_r + CW'(1);
              cur_nxt   = req.ent;
              state_nxt = (cnt_r == '0) ? S_FIN : S_UP_RD;
            end
          end else begin
            if (cnt_r == '0) begin
              status_nxt = hmq_pkg::ST_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              popped_nxt = top_r;
              cnt_nxt    = cnt_dec_w;
              // fetch the last entry
              mem_raddr  = cnt_dec_w[AW-1:0];
              state_nxt  = (cnt_dec_w == '0) ? S_DONE : S_DN_LAST;
            end
          end
        end
      end

      S_UP_RD: begin
        mem_raddr = parent_w;
        state_nxt = S_UP_CMP;
      end

      S_UP_CMP: begin
        mem_we = 1'b1;
        if (!cmp_le) begin
          // new key strictly below parent: parent moves down
          mem_wdata = mem_rdata;
          pos_nxt   = parent_w;
          state_nxt = (parent_w == '0) ? S_FIN : S_UP_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_FIN: begin
        mem_we    = 1'b1;
        state_nxt = S_DONE;
      end

      S_DN_LAST: begin
        cur_nxt   = mem_rdata;
        pos_nxt   = '0;
        state_nxt = S_DN_RDL;
      end

      S_DN_RDL: begin
        if (left_w >= cnt_w) begin
          state_nxt = S_FIN;
        end else begin
          mem_raddr = left_w[AW-1:0];
          state_nxt = S_DN_RDR;
        end
      end

      S_DN_RDR: begin
        child_nxt = mem_rdata;
        cidx_nxt  = left_w[AW-1:0];
        if (right_w < cnt_w) begin
          mem_raddr = right_w[AW-1:0];
          state_nxt = S_DN_CMP;
        end else begin
          state_nxt = S_DN_SEL;
        end
      end

      S_DN_CMP: begin
        // keep left on a tie, take right only when strictly smaller
        if (!cmp_le) begin
          child_nxt = mem_rdata;
          cidx_nxt  = right_w[AW-1:0];
        end
        state_nxt = S_DN_SEL;
      end

      S_DN_SEL: begin
        mem_we = 1'b1;
        if (cmp_le) begin
          state_nxt = S_DONE;
        end else begin
          mem_wdata = child_r;
          pos_nxt   = cidx_r;
          state_nxt = S_DN_RDL;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    cidx_r   <= cidx_nxt;
    cur_r    <= cur_nxt;
    child_r  <= child_nxt;
    popped_r <= popped_nxt;
    status_r <= status_nxt;
    // shadow copy of the root entry
    if (mem_we && mem_waddr == '0) begin
      top_r <= mem_wdata;
    end
  end

  assign req_ready  = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_DONE);
  assign res.popped = popped_r;
  assign res.top    = (cnt_r != '0) ? top_r : '0;
  assign res.count  = cnt_ext_w[hmq_pkg::COUNT_W-1:0];
  assign res.status = status_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (CW'(mem_waddr) < cnt_r))
    else $error("heap write beyond held entries");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status == hmq_pkg::ST_FULL) |-> (cnt_r == CW'(CAPACITY)))
    else $error("full status while heap not full");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status == hmq_pkg::ST_EMPTY) |-> (cnt_r == '0))
    else $error("empty status while heap holds entries");

  a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> req_ready)
    else $error("sequencer did not return to idle after result");

endmodule

`default_nettype wire

// ----- rtl/binary_min_heap_queue_unit.sv -----
// Binary min-heap priority queue: top level with ports and output register.
//
// Holds up to CAPACITY entries (signed 32-bit key plus 32-bit payload) in one
// single-port-read RAM and handles one push or pop at a time; in_ready is low
// while a transaction is in progress. Each transaction gives exactly one
// result. A pop that sinks through a level with two children needs two RAM
// reads through the one read port and two passes through the shared key
// comparator. The RAM needs no clearing after reset, so the block is ready
// as soon as reset is released. A finished result waits in the output
// register while the next transaction is accepted.
`default_nettype none

module binary_min_heap_queue_unit #(
  parameter int CAPACITY = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_operation,
  input  wire logic signed [31:0] in_key,
  input  wire logic [31:0]        in_payload,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_popped_key,
  output logic [31:0]             out_popped_payload,
  output logic signed [31:0]      out_top_key,
  output logic [31:0]             out_top_payload,
  output logic [10:0]             out_entry_count,
  output logic [1:0]              out_status
);

  localparam int AW = $clog2(CAPACITY);

  hmq_pkg::req_t   req;
  hmq_pkg::res_t   res;
  hmq_pkg::res_t   res_r;
  logic            res_valid, res_ready;
  logic            out_valid_r;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  hmq_pkg::entry_t mem_wdata, mem_rdata;

  assign req.op          = in_operation;
  assign req.ent.key     = in_key;
  assign req.ent.payload = in_payload;

  hmq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_ready (in_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  hmq_ram #(
    .WIDTH ($bits(hmq_pkg::entry_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: loads when empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_popped_key     = res_r.popped.key;
  assign out_popped_payload = res_r.popped.payload;
  assign out_top_key        = res_r.top.key;
  assign out_top_payload    = res_r.top.payload;
  assign out_entry_count    = res_r.count;
  assign out_status         = res_r.status;

endmodule

`default_nettype wire
